// ----- sv/strict_utf8_to_utf16_utf32_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the strict UTF-8 decoder
// Concurrent checks on clk_i, disabled while rst_ni is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef STRICT_UTF8_TO_UTF16_UTF32_ASSERT_SVH
`define STRICT_UTF8_TO_UTF16_UTF32_ASSERT_SVH

`ifndef SYNTHESIS
// ante |-> cons, same cycle
`define SU8_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("su8 check failed");
// ante |=> cons, next cycle
`define SU8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("su8 check failed");
`else
`define SU8_ASSERT_IMP(label, ante, cons)
`define SU8_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/su8_pkg.sv -----
// ----------------------------------------------------------------------------
// su8_pkg
// Shared types and constants of the strict UTF-8 decoder.
// ----------------------------------------------------------------------------
package su8_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned UNITS_W = 24;
  localparam int unsigned QDEPTH  = 2;

  // result status codes; also used as the closing kind of a queue entry
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_TERM     = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_CAPACITY = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_OUT_MODE = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;

  // UTF-16 surrogate construction
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [CP_W-1:0] SUR_HI    = 21'h00D800;
  localparam logic [CP_W-1:0] SUR_LO    = 21'h00DC00;

  // configuration seen by the decoder
  typedef struct packed {
    logic               out_mode;
    logic [UNITS_W-1:0] capacity;
  } su8_cfg_t;

  // one decoded byte: 0..2 data units, then an optional closing result
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [1:0]      ndata;
    logic [1:0]      fin;    // ST_DATA means no closing result
  } su8_entry_t;

endpackage

// ----- sv/strict_utf8_to_utf16_utf32.sv -----
// A byte's first result is held in a queue slot and then in the sequencer's work register
// before it is presented. Throughput: one byte per cycle while the queue is not full;
// the output port sends one result per cycle while it is ready, so a byte giving a
// surrogate pair or a unit plus terminator holds it for two or three results, and a
// 2-entry queue between decoder and sequencer absorbs the difference.
// Reset (async, active low): text state, queue and output cleared at once;
// out_mode = 1, capacity_units = 0xFFFFFF.
// ----------------------------------------------------------------------------
// strict_utf8_to_utf16_utf32
// Strict streaming UTF-8 decoder with UTF-32 or UTF-16 output and capacity check.
// ----------------------------------------------------------------------------
`include "strict_utf8_to_utf16_utf32_assert.svh"

module strict_utf8_to_utf16_utf32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last_byte
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] unit, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,   // last_result
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  su8_pkg::su8_cfg_t        cfg;
  logic                     out_mode_q;
  logic [23:0]              capacity_q;
  logic                     push;
  logic                     full;
  logic                     pop;
  logic                     empty;
  su8_pkg::su8_entry_t      push_entry;
  su8_pkg::su8_entry_t      head_entry;
  logic [su8_pkg::CP_W-1:0] unit;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_mode_q <= 1'b1;
      capacity_q <= 24'hFFFFFF;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        su8_pkg::REG_OUT_MODE: out_mode_q <= cfg_data_i[0];
        su8_pkg::REG_CAPACITY: capacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.out_mode = out_mode_q;
  assign cfg.capacity = capacity_q;

  su8_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .cfg_i   (cfg),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  su8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  su8_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .entry_i  (head_entry),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .unit_o   (unit),
    .status_o (m_axis_tuser),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, unit};

  // data units never close a text, everything else does
  `SU8_ASSERT_IMP(a_last_iff_not_data, m_axis_tvalid, (m_axis_tuser == su8_pkg::ST_DATA) == !m_axis_tlast)
  // terminator and error results carry a zero unit
  `SU8_ASSERT_IMP(a_close_unit_zero, m_axis_tvalid && m_axis_tuser != su8_pkg::ST_DATA, m_axis_tdata == 24'd0)
  // a high surrogate is followed at once by its low half
  `SU8_ASSERT_NEXT(a_pair_follows, m_axis_tvalid && m_axis_tready && m_axis_tuser == su8_pkg::ST_DATA && m_axis_tdata[20:10] == 11'h036, m_axis_tvalid && m_axis_tuser == su8_pkg::ST_DATA && m_axis_tdata[20:10] == 11'h037)

endmodule

// ----- sv/su8_front.sv -----
// ----------------------------------------------------------------------------
// su8_front
// Byte decoder: validates UTF-8, tracks the text state and the unit count,
// and pushes one entry per byte that produces results.
// ----------------------------------------------------------------------------
module su8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  su8_pkg::su8_cfg_t   cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output su8_pkg::su8_entry_t entry_o
);

  logic [7:0]                  lead_q, lead_d;
  logic [su8_pkg::CP_W-1:0]    partial_q, partial_d;
  logic [1:0]                  pending_q, pending_d;
  logic [1:0]                  cont_q, cont_d;
  logic [su8_pkg::UNITS_W-1:0] units_q, units_d;
  logic                        discard_q, discard_d;
  logic                        accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;

  // decode one byte
  always_comb begin
    logic                     have;
    logic [su8_pkg::CP_W-1:0] cp;
    logic [1:0]               err;
    logic [1:0]               need;
    logic [1:0]               ndata;
    logic [1:0]               fin;
    logic                     bad_second;
    logic [25:0]              sum;

    lead_d     = lead_q;
    partial_d  = partial_q;
    pending_d  = pending_q;
    cont_d     = cont_q;
    units_d    = units_q;
    discard_d  = discard_q;
    have       = 1'b0;
    cp         = '0;
    err        = su8_pkg::ST_DATA;
    ndata      = 2'd0;
    fin        = su8_pkg::ST_DATA;
    need       = 2'd1;
    bad_second = 1'b0;
    sum        = '0;

    if (discard_q) begin
      // drop bytes up to the end of the broken text
      if (last_i) begin
        lead_d    = '0;
        partial_d = '0;
        pending_d = '0;
        cont_d    = '0;
        units_d   = '0;
        discard_d = 1'b0;
      end
    end else begin
      if (pending_q == 2'd0) begin
        // lead byte
        if (byte_i == 8'h00) begin
          err = su8_pkg::ST_INVALID;
        end else if (byte_i < 8'h80) begin
          cp   = su8_pkg::CP_W'(byte_i);
          have = 1'b1;
        end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
          lead_d    = byte_i;
          partial_d = su8_pkg::CP_W'(byte_i[4:0]);
          pending_d = 2'd1;
          cont_d    = 2'd0;
        end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
          lead_d    = byte_i;
          partial_d = su8_pkg::CP_W'(byte_i[3:0]);
          pending_d = 2'd2;
          cont_d    = 2'd0;
        end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
          lead_d    = byte_i;
          partial_d = su8_pkg::CP_W'(byte_i[2:0]);
          pending_d = 2'd3;
          cont_d    = 2'd0;
        end else begin
          err = su8_pkg::ST_INVALID;
        end
      end else begin
        // continuation byte; second byte limits rule out overlongs,
        // surrogates and values above U+10FFFF
        bad_second = (cont_q == 2'd0) &&
                     ((lead_q == 8'hE0 && byte_i < 8'hA0) ||
                      (lead_q == 8'hED && byte_i >= 8'hA0) ||
                      (lead_q == 8'hF0 && byte_i < 8'h90) ||
                      (lead_q == 8'hF4 && byte_i >= 8'h90));
        if (byte_i[7:6] != 2'b10 || bad_second) begin
          err = su8_pkg::ST_INVALID;
        end else begin
          partial_d = {partial_q[su8_pkg::CP_W-7:0], byte_i[5:0]};
          pending_d = pending_q - 2'd1;
          cont_d    = cont_q + 2'd1;
          if (pending_d == 2'd0) begin
            cp        = partial_d;
            have      = 1'b1;
            lead_d    = '0;
            partial_d = '0;
            cont_d    = '0;
          end
        end
      end

      // capacity check for the code point, terminator slot reserved
      if (!cfg_i.out_mode || cp[su8_pkg::CP_W-1:16] == '0) begin
        need = 2'd1;
      end else begin
        need = 2'd2;
      end
      sum = 26'(units_q) + 26'(need) + 26'd1;
      if (err == su8_pkg::ST_DATA && have) begin
        if (sum > 26'(cfg_i.capacity)) begin
          err = su8_pkg::ST_CAPACITY;
        end else begin
          ndata   = need;
          units_d = units_q + su8_pkg::UNITS_W'(need);
        end
      end

      // text cut off inside a sequence
      if (err == su8_pkg::ST_DATA && last_i && pending_d != 2'd0) begin
        err = su8_pkg::ST_INVALID;
      end

      if (err != su8_pkg::ST_DATA) begin
        ndata     = 2'd0;
        fin       = err;
        lead_d    = '0;
        partial_d = '0;
        pending_d = '0;
        cont_d    = '0;
        units_d   = '0;
        discard_d = !last_i;
      end else if (last_i) begin
        // terminator, checked against capacity as well
        if (26'(units_d) + 26'd1 > 26'(cfg_i.capacity)) begin
          ndata = 2'd0;
          fin   = su8_pkg::ST_CAPACITY;
        end else begin
          fin = su8_pkg::ST_TERM;
        end
        lead_d    = '0;
        partial_d = '0;
        pending_d = '0;
        cont_d    = '0;
        units_d   = '0;
        discard_d = 1'b0;
      end
    end

    entry_o.cp    = cp;
    entry_o.ndata = ndata;
    entry_o.fin   = fin;
    push_o        = accept && (ndata != 2'd0 || fin != su8_pkg::ST_DATA);
  end

  // text state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      partial_q <= '0;
      pending_q <= '0;
      cont_q    <= '0;
      units_q   <= '0;
      discard_q <= 1'b0;
    end else if (accept) begin
      lead_q    <= lead_d;
      partial_q <= partial_d;
      pending_q <= pending_d;
      cont_q    <= cont_d;
      units_q   <= units_d;
      discard_q <= discard_d;
    end
  end

endmodule

// ----- sv/su8_queue.sv -----
// ----------------------------------------------------------------------------
// su8_queue
// Short entry queue between the byte decoder and the result sequencer.
// ----------------------------------------------------------------------------
module su8_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  su8_pkg::su8_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output su8_pkg::su8_entry_t entry_o
);

  localparam int unsigned PTR_W = (su8_pkg::QDEPTH > 1) ? $clog2(su8_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(su8_pkg::QDEPTH + 1);

  su8_pkg::su8_entry_t slot_q [su8_pkg::QDEPTH];
  logic [PTR_W-1:0]    wr_q, wr_d;
  logic [PTR_W-1:0]    rd_q, rd_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(su8_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(su8_pkg::QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(su8_pkg::QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- sv/su8_back.sv -----
// ----------------------------------------------------------------------------
// su8_back
// Result sequencer: expands one entry into data units (surrogate pair in
// UTF-16 mode) followed by its terminator or error result, if it has one.
// ----------------------------------------------------------------------------
module su8_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  su8_pkg::su8_entry_t      entry_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [su8_pkg::CP_W-1:0] unit_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  su8_pkg::su8_entry_t      work_q, work_d;
  logic                     work_valid_q, work_valid_d;
  logic [1:0]               phase_q, phase_d;
  logic [1:0]               total;
  logic                     fire;
  logic                     final_res;
  logic                     load;
  logic [su8_pkg::CP_W-1:0] v;

  assign total     = work_q.ndata + ((work_q.fin != su8_pkg::ST_DATA) ? 2'd1 : 2'd0);
  assign fire      = work_valid_q && ready_i;
  assign final_res = (phase_q == total - 2'd1);
  assign load      = !work_valid_q || (fire && final_res);
  assign pop_o     = load && !empty_i;
  assign valid_o   = work_valid_q;
  assign v         = work_q.cp - su8_pkg::SUPP_BASE;

  // current result of the entry
  always_comb begin
    unit_o   = '0;
    status_o = work_q.fin;
    last_o   = 1'b1;
    if (phase_q < work_q.ndata) begin
      status_o = su8_pkg::ST_DATA;
      last_o   = 1'b0;
      if (work_q.ndata == 2'd1) begin
        unit_o = work_q.cp;
      end else if (phase_q == 2'd0) begin
        unit_o = su8_pkg::SUR_HI | su8_pkg::CP_W'(v[19:10]);
      end else begin
        unit_o = su8_pkg::SUR_LO | su8_pkg::CP_W'(v[9:0]);
      end
    end
  end

  // step through the entry, fetch the next one after its final result
  always_comb begin
    work_d       = work_q;
    work_valid_d = work_valid_q;
    phase_d      = phase_q;
    if (load) begin
      work_valid_d = !empty_i;
      work_d       = entry_i;
      phase_d      = 2'd0;
    end else if (fire) begin
      phase_d = phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      phase_q      <= '0;
    end else begin
      work_valid_q <= work_valid_d;
      phase_q      <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strict UTF-8 decoder. Byte texts go in on the
// input stream; an in-bench decoder predicts every unit, terminator and error,
// and each result on the output stream is checked against the oldest one.
// Directed texts cover limits and rejected forms, then random texts follow.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // unused register index; writes to it must change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;
  // quiet cycles inserted before a config write and at the end
  localparam int unsigned LAT_PAUSE = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic [su8_pkg::CP_W-1:0] unit;
    logic [1:0]               status;
    logic                     last;
  } decoded_unit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [20:0] unit, [23:21] zero
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        m_axis_tlast;   // last_result
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  strict_utf8_to_utf16_utf32 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predicted results, oldest first
  decoded_unit_t expected_units[$];
  int unsigned   fail_count;
  int unsigned   bytes_decoded;   // bytes not swallowed by discarding
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  // predicted configuration
  logic         cfg_utf16;
  logic [23:0]  cfg_cap;

  // predicted text state
  logic [7:0]               dec_lead;
  logic [su8_pkg::CP_W-1:0] dec_acc;
  logic [1:0]               dec_pending;
  logic [1:0]               dec_cont;
  logic [23:0]              dec_units;
  logic                     dec_drop;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_text_state();
    dec_lead    = 8'h00;
    dec_acc     = '0;
    dec_pending = 2'd0;
    dec_cont    = 2'd0;
    dec_units   = 24'd0;
    dec_drop    = 1'b0;
  endtask

  task automatic expect_unit(input logic [su8_pkg::CP_W-1:0] unit, input logic [1:0] status,
                             input logic last);
    expected_units.push_back({unit, status, last});
  endtask

  // Predict the results of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic [1:0]               err;
    logic                     have;
    logic [su8_pkg::CP_W-1:0] cp;
    logic [su8_pkg::CP_W-1:0] offs;
    int unsigned              need;
    err  = su8_pkg::ST_DATA;   // ST_DATA here means no error
    have = 1'b0;
    cp   = '0;
    if (dec_drop) begin
      // rest of a failed text: silent, the marked byte clears
      if (lst) clear_text_state();
    end else begin
      bytes_decoded++;
      if (dec_pending == 2'd0) begin
        if (b == 8'h00) begin
          err = su8_pkg::ST_INVALID;
        end else if (b < 8'h80) begin
          cp   = {13'b0, b};
          have = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          dec_lead = b; dec_acc = {16'b0, b[4:0]}; dec_pending = 2'd1; dec_cont = 2'd0;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          dec_lead = b; dec_acc = {17'b0, b[3:0]}; dec_pending = 2'd2; dec_cont = 2'd0;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          dec_lead = b; dec_acc = {18'b0, b[2:0]}; dec_pending = 2'd3; dec_cont = 2'd0;
        end else begin
          err = su8_pkg::ST_INVALID;
        end
      end else begin
        if ((b & 8'hC0) != 8'h80) begin
          err = su8_pkg::ST_INVALID;
        end else if (dec_cont == 2'd0 &&
                     ((dec_lead == 8'hE0 && b < 8'hA0) ||
                      (dec_lead == 8'hED && b >= 8'hA0) ||
                      (dec_lead == 8'hF0 && b < 8'h90) ||
                      (dec_lead == 8'hF4 && b >= 8'h90))) begin
          // overlong, surrogate or beyond U+10FFFF
          err = su8_pkg::ST_INVALID;
        end else begin
          dec_acc     = {dec_acc[su8_pkg::CP_W-7:0], b[5:0]};
          dec_pending = dec_pending - 2'd1;
          dec_cont    = dec_cont + 2'd1;
          if (dec_pending == 2'd0) begin
            cp       = dec_acc;
            have     = 1'b1;
            dec_lead = 8'h00;
            dec_acc  = '0;
            dec_cont = 2'd0;
          end
        end
      end

      // emit the code point, room for the terminator kept in reserve
      if (err == su8_pkg::ST_DATA && have) begin
        need = (!cfg_utf16 || cp <= 21'h00FFFF) ? 1 : 2;
        if (dec_units + need + 1 > cfg_cap) begin
          err = su8_pkg::ST_CAPACITY;
        end else if (need == 1) begin
          expect_unit(cp, su8_pkg::ST_DATA, 1'b0);
          dec_units = dec_units + 24'd1;
        end else begin
          offs = cp - su8_pkg::SUPP_BASE;
          expect_unit(su8_pkg::SUR_HI | (offs >> 10), su8_pkg::ST_DATA, 1'b0);
          expect_unit(su8_pkg::SUR_LO | (offs & 21'h0003FF), su8_pkg::ST_DATA, 1'b0);
          dec_units = dec_units + 24'd2;
        end
      end

      // text cut off inside a sequence
      if (err == su8_pkg::ST_DATA && lst && dec_pending != 2'd0) err = su8_pkg::ST_INVALID;

      if (err != su8_pkg::ST_DATA) begin
        expect_unit('0, err, 1'b1);
        clear_text_state();
        if (!lst) dec_drop = 1'b1;
      end else if (lst) begin
        if (dec_units + 1 > cfg_cap) expect_unit('0, su8_pkg::ST_CAPACITY, 1'b1);
        else expect_unit('0, su8_pkg::ST_TERM, 1'b1);
        clear_text_state();
      end
    end
  endtask

  // Send one byte; valid stays high afterwards so back-to-back items need no gap
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, lst);
  endtask

  // Hold the input until every predicted result is in, then wait some more
  task automatic drain_results(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    drain_results(LAT_PAUSE);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      su8_pkg::REG_OUT_MODE: cfg_utf16 = val[0];
      su8_pkg::REG_CAPACITY: cfg_cap   = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // U+10FFFF as a surrogate pair, then the smallest nonzero byte
  task automatic test_max_code_points();
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_bad_lead_bytes();
    send_byte(8'h80, 1'b1);
    send_byte(8'hF5, 1'b1);
  endtask

  // NUL as lead (rest of the text discarded) and as continuation
  task automatic test_nul_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // surrogate and above-range forms
  task automatic test_rejected_forms();
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b1);
  endtask

  task automatic test_truncated_text();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // pair that does not fit, exact fit, and a capacity of one unit
  task automatic test_capacity_limit();
    write_reg(su8_pkg::REG_CAPACITY, 24'd2);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h41, 1'b1);
    write_reg(su8_pkg::REG_CAPACITY, 24'd1);
    send_byte(8'h41, 1'b1);
  endtask

  // switch to UTF-32 halfway through a sequence, then poke the spare index
  task automatic test_config_mid_text();
    write_reg(su8_pkg::REG_CAPACITY, 24'hFFFFFF);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    write_reg(su8_pkg::REG_OUT_MODE, 24'd0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    write_reg(REG_SPARE, 24'd0);
    send_byte(8'h41, 1'b1);
  endtask

  // Mostly well-formed texts with random content, some broken, some noise
  task automatic test_random_texts(input int unsigned quota);
    logic [7:0]  text[$];
    int unsigned cp;
    int unsigned pos;
    int unsigned start;
    start = bytes_decoded;
    while (bytes_decoded - start < quota) begin
      if ($urandom_range(3) == 0) begin
        write_reg(su8_pkg::REG_OUT_MODE, 24'($urandom_range(1)));
        case ($urandom_range(3))
          0, 1:    write_reg(su8_pkg::REG_CAPACITY, 24'($urandom_range(12, 1)));
          2:       write_reg(su8_pkg::REG_CAPACITY, 24'hFFFFFF);
          default: write_reg(su8_pkg::REG_CAPACITY, 24'($urandom_range(24'hFFFFFF, 1)));
        endcase
      end
      // sender holds off until the block has delivered everything
      if ($urandom_range(7) == 0) drain_results(0);

      text.delete();
      repeat ($urandom_range(6, 1)) begin
        case ($urandom_range(4))
          0: cp = $urandom_range(32'h7F, 1);
          1: cp = $urandom_range(32'h7FF, 32'h80);
          2: begin
            cp = $urandom_range(32'hFFFF, 32'h800);
            if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp + 32'h800;
          end
          3: cp = $urandom_range(32'h10FFFF, 32'h10000);
          default: begin
            case ($urandom_range(8))
              0: cp = 32'h7F;
              1: cp = 32'h80;
              2: cp = 32'h7FF;
              3: cp = 32'h800;
              4: cp = 32'hD7FF;
              5: cp = 32'hE000;
              6: cp = 32'hFFFF;
              7: cp = 32'h10000;
              default: cp = 32'h10FFFF;
            endcase
          end
        endcase
        if (cp < 32'h80) begin
          text.push_back(8'(cp));
        end else if (cp < 32'h800) begin
          text.push_back(8'(32'hC0 | (cp >> 6)));
          text.push_back(8'(32'h80 | (cp & 32'h3F)));
        end else if (cp < 32'h10000) begin
          text.push_back(8'(32'hE0 | (cp >> 12)));
          text.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
          text.push_back(8'(32'h80 | (cp & 32'h3F)));
        end else begin
          text.push_back(8'(32'hF0 | (cp >> 18)));
          text.push_back(8'(32'h80 | ((cp >> 12) & 32'h3F)));
          text.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
          text.push_back(8'(32'h80 | (cp & 32'h3F)));
        end
      end

      // break about a quarter of the texts
      if ($urandom_range(3) == 0) begin
        pos = $urandom_range(text.size() - 1);
        case ($urandom_range(4))
          0: text[pos] = 8'($urandom_range(255));
          1: text.push_back(8'($urandom_range(8'hF4, 8'hC2)));   // lone lead at the end
          2: text.push_back(8'($urandom_range(255)));
          3: begin
            case ($urandom_range(4))
              0: text.push_back(8'($urandom_range(8'hC1, 8'hC0)));
              1: begin
                text.push_back(8'hE0);
                text.push_back(8'($urandom_range(8'h9F, 8'h80)));
              end
              2: begin
                text.push_back(8'hED);
                text.push_back(8'($urandom_range(8'hBF, 8'hA0)));
              end
              3: begin
                text.push_back(8'hF0);
                text.push_back(8'($urandom_range(8'h8F, 8'h80)));
              end
              default: begin
                text.push_back(8'hF4);
                text.push_back(8'($urandom_range(8'hBF, 8'h90)));
              end
            endcase
            text.push_back(8'($urandom_range(8'hBF, 8'h80)));
          end
          default: begin
            text.delete();
            repeat ($urandom_range(5, 1)) text.push_back(8'($urandom_range(255)));
          end
        endcase
      end

      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    end
  endtask

  // Result checker and receiver-side stalls
  always @(posedge clk_i) begin : check_results
    decoded_unit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_units.size() == 0) begin
        fail_count++;
        if (fail_count < PRINT_LIMIT)
          $display("%0t: unexpected result expected none, actual unit=%h status=%0d last=%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = expected_units.pop_front();
        if (m_axis_tdata !== {3'b000, want.unit} || m_axis_tuser !== want.status ||
            m_axis_tlast !== want.last) begin
          fail_count++;
          if (fail_count < PRINT_LIMIT)
            $display("%0t: mismatch expected unit=%h status=%0d last=%b, actual unit=%h status=%0d last=%b",
                     $time, want.unit, want.status, want.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= su8_pkg::REG_OUT_MODE;
    cfg_data_i    <= 24'd0;
    fail_count    = 0;
    bytes_decoded = 0;
    send_idle_pct = 37;
    recv_idle_pct = 51;
    cfg_utf16     = 1'b1;
    cfg_cap       = 24'hFFFFFF;
    clear_text_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_max_code_points();
    test_bad_lead_bytes();
    test_nul_bytes();
    test_rejected_forms();
    test_truncated_text();
    test_capacity_limit();
    test_config_mid_text();
    test_random_texts(32);

    send_idle_pct = 51;
    recv_idle_pct = 37;
    write_reg(su8_pkg::REG_OUT_MODE, 24'd1);
    test_random_texts(32);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_texts(32);

    drain_results(2 * LAT_PAUSE);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- strict_utf8_to_utf16_utf32.f -----
+incdir+sv
sv/su8_pkg.sv
sv/su8_front.sv
sv/su8_queue.sv
sv/su8_back.sv
sv/strict_utf8_to_utf16_utf32.sv
tb/sv/tb_top.sv
